// ===== hdl/dpd_pkg.sv =====
// Package for the DAG phase depth block: word types, widths and defaults.
`timescale 1ns / 1ps
package dpd_pkg;

    localparam int NODE_CAPACITY_DEF = 1024;
    localparam int OPERAND_LIMIT_DEF = 4;
    localparam int FIELD_SLOTS       = 4;

    localparam int COUNT_W = 3;
    localparam int OP_W    = 10;
    localparam int PHASE_W = 8;
    localparam int HIGH_W  = 9;

    typedef struct packed {
        logic [COUNT_W-1:0] arg_count;
        logic [OP_W-1:0]    operand_a;
        logic [OP_W-1:0]    operand_b;
        logic [OP_W-1:0]    operand_c;
        logic [OP_W-1:0]    operand_d;
        logic               is_boundary;
        logic               last_node;
    } in_word_t;

    typedef struct packed {
        logic [OP_W-1:0]    node_index;
        logic [PHASE_W-1:0] node_phase;
        logic [HIGH_W-1:0]  phase_count;
        logic               bad_operand;
        logic               module_done;
    } out_word_t;

endpackage

// ===== hdl/dag_phase_depth.sv =====
// Top level of the DAG phase depth block: operand read sequencer, phase memory, result stage.
// Operands are read one at a time on the single memory read port, pausing on output stalls.
// Each word passes the input register, the read token registers and the result register.
// Words follow back to back; a write to the phase memory is forwarded to the next read.
// Reset (aresetn low, synchronous) clears node counter, highest phase and all valid flags.
// The phase memory is not cleared; read values are used only for entries already written.
`timescale 1ns / 1ps
module dag_phase_depth #(
    parameter int NODE_CAPACITY = dpd_pkg::NODE_CAPACITY_DEF,
    parameter int OPERAND_LIMIT = dpd_pkg::OPERAND_LIMIT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dpd_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dpd_pkg::out_word_t m_data
);
    import dpd_pkg::*;

    localparam int CW    = $clog2(NODE_CAPACITY + 1);
    localparam int AW    = $clog2(NODE_CAPACITY);
    localparam int CMPW  = (CW > OP_W) ? CW : OP_W;
    localparam int LIMIT = (OPERAND_LIMIT < FIELD_SLOTS) ? OPERAND_LIMIT : FIELD_SLOTS;

    logic [PHASE_W-1:0] mem [NODE_CAPACITY];

    logic [CW-1:0]      cnt_reg;
    in_word_t           a_reg;
    logic               a_valid_reg;
    logic [CW-1:0]      a_idx_reg;
    logic               a_full_reg;
    logic [1:0]         op_sel_reg;

    logic               tok_valid_reg;
    logic               tok_ok_reg;
    logic               tok_bad_reg;
    logic               tok_final_reg;
    logic               tok_full_reg;
    logic               tok_bnd_reg;
    logic               tok_last_reg;
    logic [AW-1:0]      tok_addr_reg;
    logic [CW-1:0]      tok_idx_reg;
    logic [PHASE_W-1:0] rdata_reg;

    logic               fwd_valid_reg;
    logic [AW-1:0]      fwd_addr_reg;
    logic [PHASE_W-1:0] fwd_data_reg;

    logic [PHASE_W-1:0] acc_reg;
    logic               bad_acc_reg;
    logic [HIGH_W-1:0]  hi_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    logic [COUNT_W-1:0] cnt_a;
    logic [OP_W-1:0]    op_cur;
    logic [CMPW-1:0]    op_ext;
    logic [CMPW-1:0]    idx_ext;
    logic [CMPW-1:0]    tok_idx_ext;
    logic               has_op;
    logic               earlier;
    logic               iss_ok;
    logic               iss_bad;
    logic               iss_final;
    logic               adv;
    logic               issue;
    logic               s_accept;
    logic [AW-1:0]      rd_addr;

    logic               fwd_hit;
    logic [PHASE_W-1:0] rd_val;
    logic [PHASE_W-1:0] mx;
    logic               bad_now;
    logic [HIGH_W-1:0]  phase_w;
    logic [HIGH_W-1:0]  hi_upd;
    logic               done;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;

    // issue side
    always_comb begin
        cnt_a = (a_reg.arg_count > COUNT_W'(LIMIT)) ? COUNT_W'(LIMIT)
                                                     : a_reg.arg_count;
        case (op_sel_reg)
            2'd0:    op_cur = a_reg.operand_a;
            2'd1:    op_cur = a_reg.operand_b;
            2'd2:    op_cur = a_reg.operand_c;
            default: op_cur = a_reg.operand_d;
        endcase
        op_ext    = CMPW'(op_cur);
        idx_ext   = CMPW'(a_idx_reg);
        has_op    = (cnt_a != '0);
        earlier   = (op_ext < idx_ext);
        iss_ok    = has_op && !a_full_reg && earlier;
        iss_bad   = a_full_reg || (has_op && !earlier);
        iss_final = a_full_reg || !has_op || (({1'b0, op_sel_reg} + 3'd1) == cnt_a);
        rd_addr   = op_ext[AW-1:0];
    end

    assign adv      = !(tok_valid_reg && tok_final_reg && out_valid_reg && !m_ready);
    assign issue    = a_valid_reg && adv;
    assign s_ready  = !a_valid_reg || (adv && iss_final);
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            op_sel_reg  <= '0;
            cnt_reg     <= '0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
            op_sel_reg  <= '0;
            if (s_data.last_node) begin
                cnt_reg <= '0;
            end else if (cnt_reg != CW'(NODE_CAPACITY)) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end else if (issue && iss_final) begin
            a_valid_reg <= 1'b0;
        end else if (issue) begin
            op_sel_reg <= op_sel_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_reg      <= s_data;
            a_idx_reg  <= cnt_reg;
            a_full_reg <= (cnt_reg == CW'(NODE_CAPACITY));
        end
    end

    // phase memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= phase_w[PHASE_W-1:0];
        end
        if (adv) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else if (adv) begin
            tok_valid_reg <= issue;
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tok_ok_reg    <= iss_ok;
            tok_bad_reg   <= iss_bad;
            tok_final_reg <= iss_final;
            tok_full_reg  <= a_full_reg;
            tok_bnd_reg   <= a_reg.is_boundary;
            tok_last_reg  <= a_reg.last_node;
            tok_addr_reg  <= rd_addr;
            tok_idx_reg   <= a_idx_reg;
            fwd_addr_reg  <= wr_addr;
            fwd_data_reg  <= phase_w[PHASE_W-1:0];
        end
    end

    // merge side
    always_comb begin
        fwd_hit     = fwd_valid_reg && (fwd_addr_reg == tok_addr_reg);
        rd_val      = tok_ok_reg ? (fwd_hit ? fwd_data_reg : rdata_reg) : '0;
        mx          = (rd_val > acc_reg) ? rd_val : acc_reg;
        bad_now     = bad_acc_reg || tok_bad_reg;
        phase_w     = tok_full_reg ? '0 : ({1'b0, mx} + HIGH_W'(tok_bnd_reg));
        hi_upd      = (!tok_full_reg && (phase_w > hi_reg)) ? phase_w : hi_reg;
        done        = tok_valid_reg && tok_final_reg && adv;
        wr_en       = done && !tok_full_reg;
        wr_addr     = tok_idx_reg[AW-1:0];
        tok_idx_ext = CMPW'(tok_idx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            bad_acc_reg <= 1'b0;
            hi_reg      <= '0;
        end else if (adv && tok_valid_reg) begin
            if (tok_final_reg) begin
                acc_reg     <= '0;
                bad_acc_reg <= 1'b0;
                hi_reg      <= tok_last_reg ? '0 : hi_upd;
            end else begin
                acc_reg     <= mx;
                bad_acc_reg <= bad_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (done) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            out_reg.node_index  <= tok_idx_ext[OP_W-1:0];
            out_reg.node_phase  <= phase_w[PHASE_W-1:0];
            out_reg.phase_count <= hi_upd + 1'b1;
            out_reg.bad_operand <= bad_now;
            out_reg.module_done <= tok_last_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(NODE_CAPACITY))
        else $error("node counter beyond capacity");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !(adv && iss_final)) |-> !s_ready)
        else $error("input taken while operand reads pending");

    a_stall_holds_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_valid_reg && !adv) |=> (tok_valid_reg && $stable(tok_addr_reg)
                                     && $stable(rdata_reg)))
        else $error("read token lost during stall");

    a_module_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && tok_last_reg) |=> (hi_reg == '0))
        else $error("highest phase not cleared at module end");

endmodule
